// ===== design/huffman_tree_decoder_macros.svh =====
// Assertion macros shared by the Huffman tree decoder RTL.
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define HTD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define HTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HTD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define HTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/htd_pkg.sv =====
// Types, constants and codes shared by the Huffman tree decoder.
package htd_pkg;

   // Default sizes of the node table and the code formats.
   localparam int NODE_COUNT_DEF    = 512;
   localparam int MAX_CODE_LEN_DEF  = 16;
   localparam int BITS_PER_BYTE_DEF = 7;

   // Fixed field widths of the channels.
   localparam int SYM_W      = 8;
   localparam int CODE_IN_W  = 16;
   localparam int LEN_IN_W   = 5;
   localparam int PACK_IN_W  = 7;
   localparam int STATUS_W   = 2;

   // Packed decode bits are held in a byte-wide register.
   localparam int PACK_REG_W = 8;
   localparam int PACK_IDX_W = 3;

   // Symbol value that marks an internal node.
   localparam logic [SYM_W-1:0] INTERNAL_MARK = 8'd36;

   // Request kinds.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_SYMBOL   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INS_DONE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_CHILD = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_STEP,
      S_INS_ALLOC,
      S_INS_READ,
      S_DEC_BIT,
      S_DEC_FLUSH
   } state_type;

   // Node table access controls driven by the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_left;
      logic wr_right;
   } tbl_ctl_type;

endpackage

// ===== design/htd_ifaces.sv =====
// Request and response channel interfaces of the Huffman tree decoder.
interface htd_req_if import htd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [SYM_W-1:0]     symbol;
   logic [CODE_IN_W-1:0] code_bits;
   logic [LEN_IN_W-1:0]  code_length;
   logic [PACK_IN_W-1:0] packed_bits;

   modport source (output valid, req_type, symbol, code_bits, code_length, packed_bits,
                   input ready);
   modport sink   (input valid, req_type, symbol, code_bits, code_length, packed_bits,
                   output ready);
endinterface

interface htd_rsp_if import htd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYM_W-1:0]    out_symbol;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, out_symbol, status, last, input ready);
   modport sink   (input valid, out_symbol, status, last, output ready);
endinterface

// ===== design/huffman_tree_decoder.sv =====
// Top level of the Huffman tree decoder: node table plus walk sequencer.
//
//   Channel  Direction  Payload                                         Transfer
//   req_ch   in         req_type, symbol, code_bits, code_length,        valid & ready
//                       packed_bits
//   rsp_ch   out        out_symbol, status, last                         valid & ready
//
// A decode accepts the request and reads the walk node, makes one node-table read per
// packed bit, and releases the final result in a flush step.
// An insert steps past each existing node, and links, clears and reads each new node.
// Reset clears the root flops and sets the node count to 1; entries fill on allocation.
// A pending slot and the output register let the walk run while the sink stalls;
// the walk pauses only when both hold a result, and an insert waits for a free output.
`include "huffman_tree_decoder_macros.svh"

module huffman_tree_decoder
   import htd_pkg::*;
#(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF,
   parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   htd_req_if.sink    req_ch,
   htd_rsp_if.source  rsp_ch
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int ENT_W  = NODE_W + SYM_W;

   tbl_ctl_type       tbl_ctl;
   logic [NODE_W-1:0] tbl_addr;
   logic [ENT_W-1:0]  tbl_wdata_left;
   logic [ENT_W-1:0]  tbl_wdata_right;
   logic [ENT_W-1:0]  tbl_rd_left;
   logic [ENT_W-1:0]  tbl_rd_right;

   // Child-slot storage.
   htd_node_table #(
      .NODE_COUNT (NODE_COUNT)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (tbl_ctl),
      .addr        (tbl_addr),
      .wdata_left  (tbl_wdata_left),
      .wdata_right (tbl_wdata_right),
      .rd_left     (tbl_rd_left),
      .rd_right    (tbl_rd_right)
   );

   // Insert and decode sequencer.
   htd_walk_ctrl #(
      .NODE_COUNT    (NODE_COUNT),
      .MAX_CODE_LEN  (MAX_CODE_LEN),
      .BITS_PER_BYTE (BITS_PER_BYTE)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .tbl_ctl         (tbl_ctl),
      .tbl_addr        (tbl_addr),
      .tbl_wdata_left  (tbl_wdata_left),
      .tbl_wdata_right (tbl_wdata_right),
      .tbl_rd_left     (tbl_rd_left),
      .tbl_rd_right    (tbl_rd_right)
   );

   // The table is never read and written in the same cycle.
   `HTD_ASSERT_IMPLY(a_rd_wr_excl, clock, reset, tbl_ctl.rd_en,
      !(tbl_ctl.wr_left || tbl_ctl.wr_right), "node table read and write in one cycle")
   // An accepted request makes the block busy on the next cycle.
   `HTD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_ch.valid && req_ch.ready,
      !req_ch.ready, "ready held after request transfer")
   // Only symbol results carry a symbol value.
   `HTD_ASSERT_IMPLY(a_sym_zero, clock, reset, rsp_ch.valid && (rsp_ch.status != ST_SYMBOL),
      rsp_ch.out_symbol == '0, "nonzero symbol on a status result")
   // An insert gives exactly one result, so it is always the last.
   `HTD_ASSERT_IMPLY(a_ins_last, clock, reset,
      rsp_ch.valid && ((rsp_ch.status == ST_INS_DONE) || (rsp_ch.status == ST_FULL)),
      rsp_ch.last, "insert result without last")

endmodule

// ===== design/htd_node_table.sv =====
// Node table: left and right child slots per node, root held in flops.
module htd_node_table
   import htd_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbl_ctl_type                           ctl,
   input  logic [$clog2(NODE_COUNT)-1:0]         addr,
   input  logic [$clog2(NODE_COUNT)+SYM_W-1:0]   wdata_left,
   input  logic [$clog2(NODE_COUNT)+SYM_W-1:0]   wdata_right,
   output logic [$clog2(NODE_COUNT)+SYM_W-1:0]   rd_left,
   output logic [$clog2(NODE_COUNT)+SYM_W-1:0]   rd_right
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int ENT_W  = NODE_W + SYM_W;

   // Each slot holds the child index and a copy of the child's symbol.
   logic [ENT_W-1:0] left_mem  [NODE_COUNT];
   logic [ENT_W-1:0] right_mem [NODE_COUNT];
   logic [ENT_W-1:0] left_rd_ff;
   logic [ENT_W-1:0] right_rd_ff;
   logic [ENT_W-1:0] root_left_ff;
   logic [ENT_W-1:0] root_right_ff;
   logic             rd_root_ff;
   logic             is_root;

   assign is_root = (addr == '0);

   // Memory ports for all nodes other than the root.
   always_ff @(posedge clock) begin
      if (ctl.wr_left && !is_root) begin
         left_mem[addr] <= wdata_left;
      end
      if (ctl.wr_right && !is_root) begin
         right_mem[addr] <= wdata_right;
      end
      if (ctl.rd_en) begin
         left_rd_ff  <= left_mem[addr];
         right_rd_ff <= right_mem[addr];
      end
   end

   // The root lives in flops so that reset leaves an empty tree.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_left_ff  <= '0;
         root_right_ff <= '0;
         rd_root_ff    <= 1'b1;
      end else begin
         if (ctl.wr_left && is_root) begin
            root_left_ff <= wdata_left;
         end
         if (ctl.wr_right && is_root) begin
            root_right_ff <= wdata_right;
         end
         if (ctl.rd_en) begin
            rd_root_ff <= is_root;
         end
      end
   end

   assign rd_left  = rd_root_ff ? root_left_ff  : left_rd_ff;
   assign rd_right = rd_root_ff ? root_right_ff : right_rd_ff;

endmodule

// ===== design/htd_walk_ctrl.sv =====
// Sequencer that walks the node table for code inserts and bit decodes.
module htd_walk_ctrl
   import htd_pkg::*;
#(
   parameter int NODE_COUNT    = NODE_COUNT_DEF,
   parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF,
   parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   htd_req_if.sink                               req_ch,
   htd_rsp_if.source                             rsp_ch,
   output tbl_ctl_type                           tbl_ctl,
   output logic [$clog2(NODE_COUNT)-1:0]         tbl_addr,
   output logic [$clog2(NODE_COUNT)+SYM_W-1:0]   tbl_wdata_left,
   output logic [$clog2(NODE_COUNT)+SYM_W-1:0]   tbl_wdata_right,
   input  logic [$clog2(NODE_COUNT)+SYM_W-1:0]   tbl_rd_left,
   input  logic [$clog2(NODE_COUNT)+SYM_W-1:0]   tbl_rd_right
);

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int ENT_W      = NODE_W + SYM_W;
   localparam int CNT_W      = $clog2(NODE_COUNT + 1);
   localparam int LEN_W      = $clog2(MAX_CODE_LEN + 1);
   localparam int CODE_REG_W = (MAX_CODE_LEN > CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
   localparam int CIDX_W     = $clog2(CODE_REG_W);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      nodes_ff, nodes_in;
   logic [NODE_W-1:0]     walk_ff, walk_in;
   logic [NODE_W-1:0]     node_ff, node_in;
   logic [NODE_W-1:0]     parent_ff, parent_in;
   logic                  side_ff, side_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [CODE_REG_W-1:0] code_ff, code_in;
   logic [SYM_W-1:0]      symbol_ff, symbol_in;
   logic [PACK_REG_W-1:0] pk_ff, pk_in;
   logic [PACK_IDX_W-1:0] bidx_ff, bidx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]      pend_sym_ff, pend_sym_in;
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]      rsp_sym_ff, rsp_sym_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  push;
   logic [SYM_W-1:0]      push_sym;
   logic [STATUS_W-1:0]   push_status;
   logic                  push_last;
   logic                  req_ready;

   logic [LEN_W-1:0]      len_clamp;
   logic [LEN_W-1:0]      len_m1;
   logic [CIDX_W-1:0]     code_idx;
   logic                  ins_bit;
   logic [ENT_W-1:0]      ins_slot;
   logic [NODE_W-1:0]     ins_ptr;
   logic                  table_full;
   logic [NODE_W-1:0]     new_node;

   logic                  dec_bit;
   logic [ENT_W-1:0]      dec_ent;
   logic [NODE_W-1:0]     dec_ptr;
   logic [SYM_W-1:0]      dec_csym;
   logic                  dec_hit;
   logic [SYM_W-1:0]      dec_sym;
   logic [STATUS_W-1:0]   dec_status;
   logic [NODE_W-1:0]     dec_next;
   logic                  dec_stall;

   // Insert step: pick the slot for the current code bit.
   assign len_clamp  = (int'(req_ch.code_length) > MAX_CODE_LEN) ?
                       LEN_W'(MAX_CODE_LEN) : LEN_W'(req_ch.code_length);
   assign len_m1     = len_ff - LEN_W'(1);
   assign code_idx   = CIDX_W'(len_m1);
   assign ins_bit    = code_ff[code_idx];
   assign ins_slot   = ins_bit ? tbl_rd_right : tbl_rd_left;
   assign ins_ptr    = ins_slot[ENT_W-1:SYM_W];
   assign table_full = (nodes_ff == CNT_W'(NODE_COUNT));
   assign new_node   = NODE_W'(nodes_ff);

   // Decode step: follow one child and see whether it ends a code.
   assign dec_bit    = pk_ff[bidx_ff];
   assign dec_ent    = dec_bit ? tbl_rd_right : tbl_rd_left;
   assign dec_ptr    = dec_ent[ENT_W-1:SYM_W];
   assign dec_csym   = dec_ent[SYM_W-1:0];
   assign dec_hit    = (dec_ptr == '0) || (dec_csym != INTERNAL_MARK);
   assign dec_status = (dec_ptr == '0) ? ST_NO_CHILD : ST_SYMBOL;
   assign dec_sym    = (dec_ptr == '0) ? '0 : dec_csym;
   assign dec_next   = dec_hit ? '0 : dec_ptr;

   // The result register can take a new transfer this cycle.
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign dec_stall  = dec_hit && pend_valid_ff && !out_free;

   // Next state, table accesses and result pushes.
   always_comb begin
      state_in        = state_ff;
      nodes_in        = nodes_ff;
      walk_in         = walk_ff;
      node_in         = node_ff;
      parent_in       = parent_ff;
      side_in         = side_ff;
      len_in          = len_ff;
      code_in         = code_ff;
      symbol_in       = symbol_ff;
      pk_in           = pk_ff;
      bidx_in         = bidx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_sym_in     = pend_sym_ff;
      pend_status_in  = pend_status_ff;
      tbl_ctl         = '0;
      tbl_addr        = '0;
      tbl_wdata_left  = '0;
      tbl_wdata_right = '0;
      push            = 1'b0;
      push_sym        = '0;
      push_status     = ST_SYMBOL;
      push_last       = 1'b0;
      req_ready       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               tbl_ctl.rd_en = 1'b1;
               if (req_ch.req_type == REQ_INSERT) begin
                  tbl_addr  = '0;
                  node_in   = '0;
                  len_in    = len_clamp;
                  code_in   = CODE_REG_W'(req_ch.code_bits);
                  symbol_in = req_ch.symbol;
                  state_in  = S_INS_STEP;
               end else begin
                  tbl_addr = walk_ff;
                  pk_in    = PACK_REG_W'(req_ch.packed_bits);
                  bidx_in  = PACK_IDX_W'(BITS_PER_BYTE - 1);
                  state_in = S_DEC_BIT;
               end
            end
         end

         S_INS_STEP: begin
            priority if (len_ff == '0) begin
               // End of code: store the symbol in the parent's slot copy.
               if (out_free) begin
                  if (node_ff != '0) begin
                     tbl_addr = parent_ff;
                     if (side_ff) begin
                        tbl_ctl.wr_right = 1'b1;
                        tbl_wdata_right  = {node_ff, symbol_ff};
                     end else begin
                        tbl_ctl.wr_left = 1'b1;
                        tbl_wdata_left  = {node_ff, symbol_ff};
                     end
                  end
                  push        = 1'b1;
                  push_status = ST_INS_DONE;
                  push_last   = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (ins_ptr != '0) begin
               // Child exists: read it and go one level down.
               tbl_ctl.rd_en = 1'b1;
               tbl_addr      = ins_ptr;
               parent_in     = node_ff;
               side_in       = ins_bit;
               node_in       = ins_ptr;
               len_in        = len_m1;
            end else if (table_full) begin
               if (out_free) begin
                  push        = 1'b1;
                  push_status = ST_FULL;
                  push_last   = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               // Link a fresh internal node into the parent's slot.
               tbl_addr = node_ff;
               if (ins_bit) begin
                  tbl_ctl.wr_right = 1'b1;
                  tbl_wdata_right  = {new_node, INTERNAL_MARK};
               end else begin
                  tbl_ctl.wr_left = 1'b1;
                  tbl_wdata_left  = {new_node, INTERNAL_MARK};
               end
               parent_in = node_ff;
               side_in   = ins_bit;
               node_in   = new_node;
               len_in    = len_m1;
               nodes_in  = nodes_ff + CNT_W'(1);
               state_in  = S_INS_ALLOC;
            end
         end

         S_INS_ALLOC: begin
            // A new node starts with no children.
            tbl_ctl.wr_left  = 1'b1;
            tbl_ctl.wr_right = 1'b1;
            tbl_addr         = node_ff;
            state_in         = S_INS_READ;
         end

         S_INS_READ: begin
            tbl_ctl.rd_en = 1'b1;
            tbl_addr      = node_ff;
            state_in      = S_INS_STEP;
         end

         S_DEC_BIT: begin
            if (!dec_stall) begin
               tbl_ctl.rd_en = 1'b1;
               tbl_addr      = dec_next;
               walk_in       = dec_next;
               if (dec_hit) begin
                  // Hold each result until the next one shows it is not the last.
                  if (pend_valid_ff) begin
                     push        = 1'b1;
                     push_sym    = pend_sym_ff;
                     push_status = pend_status_ff;
                  end
                  pend_valid_in  = 1'b1;
                  pend_sym_in    = dec_sym;
                  pend_status_in = dec_status;
               end
               if (bidx_ff == '0) begin
                  state_in = S_DEC_FLUSH;
               end else begin
                  bidx_in = bidx_ff - PACK_IDX_W'(1);
               end
            end
         end

         S_DEC_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_sym      = pend_sym_ff;
               push_status   = pend_status_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register: loads on a push, empties on a transfer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_sym_in    = push_sym;
         rsp_status_in = push_status;
         rsp_last_in   = push_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff      <= CNT_W'(1);
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         nodes_ff      <= nodes_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      node_ff        <= node_in;
      parent_ff      <= parent_in;
      side_ff        <= side_in;
      len_ff         <= len_in;
      code_ff        <= code_in;
      symbol_ff      <= symbol_in;
      pk_ff          <= pk_in;
      bidx_ff        <= bidx_in;
      pend_sym_ff    <= pend_sym_in;
      pend_status_ff <= pend_status_in;
      rsp_sym_ff     <= rsp_sym_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_symbol = rsp_sym_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule
